/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file sfr_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, off while reset is high
`define SFR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stream_find_replace assertion failed");

// concurrent assertion that also holds across reset
`define SFR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("stream_find_replace assertion failed");

`endif

/* hdl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// types and constants for the streaming find-and-replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int DATA_W      = 64;
  localparam int PADDR_W     = 5;
  localparam int REPL_MAX    = 8;
  localparam int COUNT_W     = 4;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       line_done;
    logic       run_last;
  } result_t;

endpackage

/* hdl/stream_find_replace.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace
// replaces each leftmost non-overlapping pattern occurrence in a byte stream
// ----------------------------------------------------------------------------
// Item channel (item_valid/item_ready/item) carries one byte or an
// end-of-line mark per transfer. Result channel (result_valid/result_ready/
// result) carries one output byte or the line-end marker per transfer;
// run_last flags the final result caused by an item.
// Pattern and replacement are set over the APB port while the block is idle;
// a write to pattern_length empties the pending window.
// Latency: results of an item appear the cycle after its transfer.
// Throughput: one item per cycle while the receiver is ready and each item
// causes at most one result. A burst holds the result register until its
// last result is transferred, as the burst register drains one result per
// ready cycle; the next item is taken in the cycle of that last transfer.
// A stalled receiver holds the current result steady and, once the burst
// register is occupied, holds off the item channel.
// Reset empties the window and the burst register and loads the register
// defaults (pattern length 1, empty replacement).
// ----------------------------------------------------------------------------
module stream_find_replace #(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  sfr_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output sfr_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [sfr_pkg::DATA_W-1:0]   pwdata,
  output logic [sfr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

  // configuration registers
  logic [sfr_pkg::DATA_W-1:0]  pattern_bytes;
  logic [3:0]                  pattern_length;
  logic [sfr_pkg::DATA_W-1:0]  replacement_bytes;
  logic [3:0]                  replacement_length;

  // pending window and burst register
  window_t                     window;
  window_t                     window_next;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [sfr_pkg::DATA_W-1:0]  burst_word;
  logic [sfr_pkg::COUNT_W-1:0] burst_count;
  logic                        burst_marker;

  logic [FILL_W-1:0]           plen;
  logic [sfr_pkg::COUNT_W-1:0] rlen;
  logic [FILL_W-1:0]           fill_inc;
  window_t                     win_ins;
  window_t                     win_shift;
  logic                        match;
  logic                        load;
  logic [sfr_pkg::DATA_W-1:0]  load_word;
  logic [sfr_pkg::COUNT_W-1:0] load_count;
  logic                        load_marker;
  logic                        item_xfer;
  logic                        result_xfer;
  logic                        cfg_write;
  sfr_pkg::reg_idx_t           reg_idx;

  assign reg_idx   = sfr_pkg::reg_idx_t'(paddr[sfr_pkg::PADDR_W-1:3]);
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes;
      sfr_pkg::REG_PATTERN_LENGTH:     prdata = sfr_pkg::DATA_W'(pattern_length);
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = sfr_pkg::DATA_W'(replacement_length);
      default:                         prdata = '0;
    endcase
  end

  // effective lengths: zero pattern length acts as one, both saturate
  always_comb begin
    if (pattern_length == 4'd0) begin
      plen = FILL_W'(1);
    end else if (32'(pattern_length) > MAX_PATTERN_BYTES) begin
      plen = FILL_W'(MAX_PATTERN_BYTES);
    end else begin
      plen = pattern_length[FILL_W-1:0];
    end
    if (32'(replacement_length) > sfr_pkg::REPL_MAX) begin
      rlen = sfr_pkg::COUNT_W'(sfr_pkg::REPL_MAX);
    end else begin
      rlen = replacement_length;
    end
  end

  // new byte lands at the fill position, then the full window is compared
  always_comb begin
    fill_inc = fill + FILL_W'(1);
    match    = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      win_ins[i] = (FILL_W'(i) == fill) ? item.byte_in : window[i];
      if ((FILL_W'(i) < plen) && (win_ins[i] != pattern_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    win_shift = win_ins >> 8;
  end

  always_comb begin
    window_next = window;
    fill_next   = fill;
    load        = 1'b0;
    load_word   = '0;
    load_count  = '0;
    load_marker = 1'b0;
    if (item.end_of_line) begin
      load        = 1'b1;
      load_word   = sfr_pkg::DATA_W'(window);
      load_count  = sfr_pkg::COUNT_W'(fill);
      load_marker = 1'b1;
      fill_next   = '0;
    end else if (fill_inc == plen) begin
      if (match) begin
        load        = (rlen != '0);
        load_word   = replacement_bytes;
        load_count  = rlen;
        window_next = win_ins;
        fill_next   = '0;
      end else begin
        // oldest byte leaves, window stays one short of full
        load        = 1'b1;
        load_word   = sfr_pkg::DATA_W'(win_ins[0]);
        load_count  = sfr_pkg::COUNT_W'(1);
        window_next = win_shift;
        fill_next   = fill;
      end
    end else begin
      window_next = win_ins;
      fill_next   = fill_inc;
    end
  end

  // result view of the burst register: bytes first, then the line-end marker
  always_comb begin
    result_valid = (burst_count != '0) || burst_marker;
    if (burst_count != '0) begin
      result.byte_out   = burst_word[7:0];
      result.byte_valid = 1'b1;
      result.line_done  = 1'b0;
      result.run_last   = (burst_count == sfr_pkg::COUNT_W'(1)) && !burst_marker;
    end else begin
      result.byte_out   = 8'd0;
      result.byte_valid = 1'b0;
      result.line_done  = burst_marker;
      result.run_last   = burst_marker;
    end
  end

  assign result_xfer = result_valid & result_ready;
  assign item_ready  = !result_valid || (result_ready && result.run_last);
  assign item_xfer   = item_valid & item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill               <= '0;
      burst_count        <= '0;
      burst_marker       <= 1'b0;
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= 4'd0;
    end else begin
      if (item_xfer && load) begin
        burst_count  <= load_count;
        burst_marker <= load_marker;
      end else if (result_xfer) begin
        if (burst_count != '0) begin
          burst_count <= burst_count - sfr_pkg::COUNT_W'(1);
        end else begin
          burst_marker <= 1'b0;
        end
      end
      if (cfg_write && (reg_idx == sfr_pkg::REG_PATTERN_LENGTH)) begin
        fill <= '0;
      end else if (item_xfer) begin
        fill <= fill_next;
      end
      if (cfg_write) begin
        unique case (reg_idx)
          sfr_pkg::REG_PATTERN_BYTES: begin
            pattern_bytes <= pwdata;
          end
          sfr_pkg::REG_PATTERN_LENGTH: begin
            pattern_length <= pwdata[3:0];
          end
          sfr_pkg::REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= pwdata;
          end
          sfr_pkg::REG_REPLACEMENT_LENGTH: begin
            replacement_length <= pwdata[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer && load) begin
      burst_word <= load_word;
    end else if (result_xfer && (burst_count != '0)) begin
      burst_word <= burst_word >> 8;
    end
    if (item_xfer) begin
      window <= window_next;
    end
  end

endmodule

/* hdl/sfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// port-level assertions for stream_find_replace
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input sfr_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input sfr_pkg::result_t result
);

  // a stalled result holds
  `SFR_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result))

  // every result is either a character or the line-end marker
  `SFR_ASSERT(a_result_kind, clk, rst, result_valid |-> result.byte_valid != result.line_done)

  // the line-end marker carries no character and closes the item's run
  `SFR_ASSERT(a_line_end, clk, rst, result_valid && result.line_done |-> result.byte_out == 8'd0 && result.run_last)

  // an end-of-line transfer always yields at least its marker
  `SFR_ASSERT(a_eol_result, clk, rst, item_valid && item_ready && item.end_of_line |=> result_valid)

  // nothing is offered right after reset
  `SFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

/* tb/sfr_replace_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_replace_checker
// watches the item, result and register ports of stream_find_replace, keeps
// its own copy of the pending window and registers, works out the results of
// every item transfer and compares them in order with the result transfers
// ----------------------------------------------------------------------------
module sfr_replace_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_ready,
  input  sfr_pkg::item_t              item,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  sfr_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
  output int                          error_count,
  output int                          outstanding
);

  localparam int WINDOW_MAX = 8;

  logic [63:0]      pat_word;
  logic [3:0]       pat_len_reg;
  logic [63:0]      repl_word;
  logic [3:0]       repl_len_reg;
  logic [7:0]       window [WINDOW_MAX];
  int unsigned      fill;
  sfr_pkg::result_t due_results [$];
  int               errors = 0;

  function automatic sfr_pkg::result_t char_result(input logic [7:0] b);
    sfr_pkg::result_t r;
    r = '0;
    r.byte_out = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  // window update and the burst of results one item causes
  task automatic predict_item(input sfr_pkg::item_t it);
    int unsigned      plen;
    int unsigned      rlen;
    bit               hit;
    sfr_pkg::result_t burst [$];
    sfr_pkg::result_t r;
    plen = (pat_len_reg == 0) ? 1 : (pat_len_reg > WINDOW_MAX) ? WINDOW_MAX : pat_len_reg;
    rlen = (repl_len_reg > sfr_pkg::REPL_MAX) ? sfr_pkg::REPL_MAX : repl_len_reg;
    if (fill > plen) fill = 0;
    if (it.end_of_line) begin
      for (int i = 0; i < fill; i++) burst.push_back(char_result(window[i]));
      r = '0;
      r.line_done = 1'b1;
      burst.push_back(r);
      fill = 0;
    end else begin
      if (fill < WINDOW_MAX) begin
        window[fill] = it.byte_in;
        fill++;
      end
      if (fill >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (window[i] != pat_word[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < rlen; i++) burst.push_back(char_result(repl_word[8*i +: 8]));
          fill = 0;
        end else begin
          // oldest byte leaves, window slides by one
          burst.push_back(char_result(window[0]));
          for (int i = 1; i < fill; i++) window[i-1] = window[i];
          fill--;
        end
      end
    end
    foreach (burst[i]) begin
      r = burst[i];
      r.run_last = (i == burst.size() - 1);
      due_results.push_back(r);
    end
  endtask

  task automatic check_result(input sfr_pkg::result_t got);
    sfr_pkg::result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: byte_out %0h byte_valid %0b line_done %0b run_last %0b",
             got.byte_out, got.byte_valid, got.line_done, got.run_last);
      errors++;
    end else begin
      want = due_results.pop_front();
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %0h, actual %0h", want.byte_out, got.byte_out);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.line_done !== want.line_done) begin
        $error("line_done: expected %0b, actual %0b", want.line_done, got.line_done);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_word = '0;
      pat_len_reg = 4'd1;
      repl_word = '0;
      repl_len_reg = '0;
      fill = 0;
      foreach (window[i]) window[i] = '0;
      due_results.delete();
    end else begin
      // results of an item never leave in its own transfer cycle
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) predict_item(item);
      if (psel && penable && pwrite && pready) begin
        case (sfr_pkg::reg_idx_t'(paddr[sfr_pkg::PADDR_W-1:3]))
          sfr_pkg::REG_PATTERN_BYTES: pat_word = pwdata;
          sfr_pkg::REG_PATTERN_LENGTH: begin
            pat_len_reg = pwdata[3:0];
            fill = 0;
          end
          sfr_pkg::REG_REPLACEMENT_BYTES: repl_word = pwdata;
          sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len_reg = pwdata[3:0];
          default: ;
        endcase
      end
    end
    error_count <= errors;
    outstanding <= due_results.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives lines of bytes and register settings into stream_find_replace with
// random idle and stall phases; the checker beside the block judges results
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 45;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_ready;
  sfr_pkg::item_t              item = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  sfr_pkg::result_t            result;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [sfr_pkg::PADDR_W-1:0] paddr = '0;
  logic [sfr_pkg::DATA_W-1:0]  pwdata = '0;
  logic [sfr_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  int                          error_count;
  int                          outstanding;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          sent = 0;
  logic [63:0] cur_pattern = '0;
  int          cur_plen = 1;

  stream_find_replace i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  sfr_replace_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // returns at the edge where the item transfer happens, valid still high
  task automatic send_item(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= sfr_pkg::item_t'({b, eol});
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected result is out and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] pat, input logic [3:0] plen_code,
                           input logic [63:0] repl, input logic [3:0] rlen_code);
    settle();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, plen_code});
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, repl);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen_code});
    cur_pattern = pat;
    cur_plen = (plen_code == 0) ? 1 : (plen_code > 8) ? 8 : plen_code;
  endtask

  task automatic send_pattern();
    for (int i = 0; i < cur_plen; i++) send_item(cur_pattern[8*i +: 8], 1'b0);
  endtask

  task automatic random_phase(input int phase, input int idle, input int stall);
    logic [63:0] pat;
    logic [3:0]  plen_code;
    logic [3:0]  rlen_code;
    int          pick;
    int          k;
    if ($urandom_range(1)) begin
      pat = {$urandom, $urandom};
    end else begin
      // two-letter alphabet gives self-overlapping patterns
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
    end
    plen_code = (phase == 0) ? 4'd1 : (phase == 1) ? 4'd8 : 4'($urandom_range(7, 2));
    rlen_code = (phase == 0) ? 4'd8 : (phase == 1) ? 4'd0 : 4'($urandom_range(8));
    configure(pat, plen_code, {$urandom, $urandom}, rlen_code);
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      pick = $urandom_range(9);
      if (pick <= 4) begin
        send_pattern();
      end else if (pick <= 6) begin
        // broken occurrence: a prefix then a stray byte
        k = $urandom_range(cur_plen - 1);
        for (int i = 0; i < k; i++) send_item(cur_pattern[8*i +: 8], 1'b0);
        send_item(8'($urandom), 1'b0);
      end else if (pick == 7) begin
        send_item(8'($urandom), 1'b0);
      end else if (pick == 8) begin
        k = $urandom_range(cur_plen - 1);
        send_item(cur_pattern[8*k +: 8], 1'b0);
      end else begin
        send_item(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: pattern is a single zero byte, replacement empty
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);

    configure(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_pattern();
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);

    // zero length acts as one, replacement length saturates at eight
    configure(64'h0000_0000_0000_00FF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
    send_item(8'hFF, 1'b0);
    send_item(8'h7E, 1'b0);

    // pattern length saturates at eight
    configure(64'h8000_00FF_0000_0001, 4'd15, 64'h0000_0000_0000_0042, 4'd1);
    send_pattern();
    send_item(8'h00, 1'b1);

    random_phase(0, 0, 0);
    random_phase(1, 72, 0);
    random_phase(2, 0, 72);
    random_phase(3, 36, 36);

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/sfr_pkg.sv
hdl/stream_find_replace.sv
hdl/sfr_checker.sv
tb/sfr_replace_checker.sv
tb/tb_top.sv
